// File: hw/rtl/monotone_spline_weight_eval_top_defines.svh
// assertion macros for the monotone spline evaluator
// used by monotone_spline_weight_eval_top.sv, needs clk_i and rst_ni in scope
`ifndef MONOTONE_SPLINE_WEIGHT_EVAL_TOP_DEFINES_SVH
`define MONOTONE_SPLINE_WEIGHT_EVAL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MSWE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mswe assertion failed");

// next-cycle implication, checked out of reset
`define MSWE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mswe assertion failed");

`endif

// File: hw/rtl/mswe_pkg.sv
// types and constants of the monotone spline evaluator
// no dependencies
package mswe_pkg;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_RANGE_LOW    = 3'd0,
    REG_INVERSE_STEP = 3'd1,
    REG_KNOT_COUNT   = 3'd2,
    REG_LOWER_CLAMP  = 3'd3,
    REG_UPPER_CLAMP  = 3'd4
  } reg_idx_e;

  // saturation limit of intermediate sums, 2^62
  localparam logic signed [64:0] SAT_POS = 65'sh0_4000_0000_0000_0000;
  localparam logic signed [64:0] SAT_NEG = -65'sh0_4000_0000_0000_0000;
  localparam logic [96:0] SAT_MAG = 97'h0_4000_0000_0000_0000;
  localparam logic signed [64:0] I32_POS = 65'sh0_0000_0000_7fff_ffff;
  localparam logic signed [64:0] I32_NEG = -65'sh0_0000_0000_8000_0000;

  // data that rides along the horner steps
  typedef struct packed {
    logic signed [50:0] fx;
    logic signed [34:0] c1;
    logic signed [39:0] c2;
    logic signed [31:0] p2;
  } hcar_t;

endpackage

// File: hw/rtl/monotone_spline_weight_eval_top.sv
// monotone cubic hermite spline evaluator, top level
// depends on mswe_pkg and monotone_spline_weight_eval_top_defines.svh
// One word enters per cycle unless the output stalls; each evaluate word that is
// taken gives one result at the output, and write words leave no result. Knot
// writes land in stage 5, where the knot store is read, so writes and evaluates
// take effect in arrival order. The knot store is kept as eight copies so that
// the eight knots of one evaluation are read in the same cycle. A stall at the
// output holds the whole pipeline. The three horner products each take four
// stages (magnitude, four partial products of operands split at bit 32, sum and
// saturate, signed add). Knots that were never written read as anything.
`include "monotone_spline_weight_eval_top_defines.svh"
module monotone_spline_weight_eval_top #(
  parameter int MAX_KNOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [5:0]         knot_index_i,
  input  logic signed [31:0] knot_value_i,
  input  logic signed [31:0] param_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] spline_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mswe_pkg::*;

  localparam int IW = $clog2(MAX_KNOTS);

  // configuration registers
  logic signed [31:0] range_low_q, lower_clamp_q, upper_clamp_q;
  logic [31:0]        inverse_step_q;
  logic [6:0]         knot_count_q;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q    <= 32'sd0;
      inverse_step_q <= 32'd65536;
      knot_count_q   <= 7'd3;
      lower_clamp_q  <= 32'sh8000_0000;
      upper_clamp_q  <= 32'sh7fff_ffff;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RANGE_LOW:    range_low_q    <= pwdata;
        REG_INVERSE_STEP: inverse_step_q <= pwdata;
        REG_KNOT_COUNT:   knot_count_q   <= pwdata[6:0];
        REG_LOWER_CLAMP:  lower_clamp_q  <= pwdata;
        REG_UPPER_CLAMP:  upper_clamp_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_RANGE_LOW:    prdata = range_low_q;
      REG_INVERSE_STEP: prdata = inverse_step_q;
      REG_KNOT_COUNT:   prdata = {25'd0, knot_count_q};
      REG_LOWER_CLAMP:  prdata = lower_clamp_q;
      REG_UPPER_CLAMP:  prdata = upper_clamp_q;
      default:          prdata = 32'd0;
    endcase
  end

  // pipeline advance: whole pipe holds while the output word waits
  logic en, out_valid_q;
  logic signed [31:0] out_value_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign spline_value_o = out_value_q;

  // valid bits of stages 1..9
  logic [9:1] v_q;

  // stage 1: input word, offset from range start
  logic               kind1_q;
  logic [5:0]         idx1_q;
  logic signed [31:0] val1_q;
  logic signed [32:0] diff1_q;
  // stage 2: magnitude of scaled parameter
  logic               kind2_q, neg2_q;
  logic [5:0]         idx2_q;
  logic signed [31:0] val2_q;
  logic [48:0]        mag2_q;
  // stage 3: t and segment
  logic               kind3_q;
  logic [5:0]         idx3_q;
  logic signed [31:0] val3_q;
  logic signed [49:0] t3_q;
  logic signed [33:0] ix3_q;
  // stage 4: knot addresses and fraction
  logic               kind4_q;
  logic [5:0]         idx4_q;
  logic signed [31:0] val4_q;
  logic [IW-1:0]      ia4_q [4];
  logic signed [50:0] fx4_q;
  // stage 5: knot data
  logic [31:0]        rd5_q [8];
  logic signed [50:0] fx5_q;
  // stage 6: deltas
  logic signed [32:0] d6_q [4];
  logic signed [31:0] p2_6_q;
  logic signed [50:0] fx6_q;
  // stage 7: averaged slopes
  logic signed [32:0] d7_q [4];
  logic signed [32:0] m7_q [3];
  logic signed [31:0] p2_7_q;
  logic signed [50:0] fx7_q;
  // stage 8: limited slopes
  logic signed [32:0] d32_8_q;
  logic signed [34:0] m2_8_q, m3_8_q;
  logic signed [31:0] p2_8_q;
  logic signed [50:0] fx8_q;
  // stage 9: cubic coefficients
  logic signed [39:0] c3_9_q;
  hcar_t              car9_q;

  // knot count saturated to 3..MAX_KNOTS, top segment index
  logic [31:0]        n_w;
  logic signed [35:0] top_w;
  always_comb begin
    n_w = 32'(knot_count_q);
    if (n_w < 32'd3) n_w = 32'd3;
    if (n_w > 32'(MAX_KNOTS)) n_w = 32'(MAX_KNOTS);
    top_w = 36'(n_w) - 36'sd2;
  end

  // stage 2 product of offset magnitude and inverse step
  logic [32:0] adiff_w;
  logic [64:0] prod_w;
  assign adiff_w = diff1_q[32] ? 33'(-diff1_q) : 33'(diff1_q);
  assign prod_w  = 65'(adiff_w) * 65'(inverse_step_q);

  // stage 4 clamped neighbor indices
  logic [IW-1:0]      ia_d [4];
  logic signed [35:0] cand_w [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand_w[k] = 36'(ix3_q) + 36'(k - 1);
      if (cand_w[k] < 36'sd0)       ia_d[k] = '0;
      else if (cand_w[k] > top_w)   ia_d[k] = IW'(top_w);
      else                          ia_d[k] = IW'(cand_w[k]);
    end
  end

  // stage 7 averaged slopes, zero unless both neighboring deltas are positive or both negative
  logic signed [33:0] s7_w [3];
  logic signed [32:0] m7_d [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s7_w[k] = 34'(d6_q[k]) + 34'(d6_q[k+1]);
      m7_d[k] = 33'((s7_w[k] + 34'(s7_w[k][33])) >>> 1);
      if (!((d6_q[k] > 0 && d6_q[k+1] > 0) || (d6_q[k] < 0 && d6_q[k+1] < 0)))
        m7_d[k] = '0;
    end
  end

  // stage 8 positivity and 3x limits
  logic signed [35:0] m2x, m3x, m4x, d21x, d32x, d43x, d32t, d43t;
  logic               b1p, a2p, b2p, a3p, a2g, b2g, a3g, b3g;
  logic signed [34:0] m2_d, m3_d;
  always_comb begin
    m2x  = 36'(m7_q[0]);
    m3x  = 36'(m7_q[1]);
    m4x  = 36'(m7_q[2]);
    d21x = 36'(d7_q[0]);
    d32x = 36'(d7_q[1]);
    d43x = 36'(d7_q[2]);
    d32t = 36'sd3 * d32x;
    d43t = 36'sd3 * d43x;
    b1p = d21x > 0 && m2x > 0;
    a2p = d32x > 0 && m2x > 0;
    b2p = d32x > 0 && m3x > 0;
    a3p = d43x > 0 && m3x > 0;
    a2g = d32x > 0 && m2x > d32t;
    b2g = d32x > 0 && m3x > d32t;
    a3g = d43x > 0 && m3x > d43t;
    b3g = d43x > 0 && m4x > d43t;
    if (a2g || b2g)      m2_d = 35'(d32t);
    else if (b1p && a2p) m2_d = 35'(m2x);
    else                 m2_d = '0;
    if (a3g || b3g)      m3_d = 35'(d43t);
    else if (b2p && a3p) m3_d = 35'(m3x);
    else                 m3_d = '0;
  end

  // front pipeline valid bits; a write word ends at stage 5
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q[1] <= in_valid_i;
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3];
      v_q[5] <= v_q[4] && (kind4_q == KIND_EVAL);
      v_q[9:6] <= v_q[8:5];
    end
  end

  // front pipeline data
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= kind_i;
      idx1_q  <= knot_index_i;
      val1_q  <= knot_value_i;
      diff1_q <= 33'(param_value_i) - 33'(range_low_q);

      kind2_q <= kind1_q;
      idx2_q  <= idx1_q;
      val2_q  <= val1_q;
      neg2_q  <= diff1_q[32];
      mag2_q  <= prod_w[64:16];

      kind3_q <= kind2_q;
      idx3_q  <= idx2_q;
      val3_q  <= val2_q;
      t3_q    <= neg2_q ? -50'(mag2_q) : 50'(mag2_q);
      ix3_q   <= neg2_q ? -34'(mag2_q[48:16]) : 34'(mag2_q[48:16]);

      kind4_q <= kind3_q;
      idx4_q  <= idx3_q;
      val4_q  <= val3_q;
      ia4_q   <= ia_d;
      fx4_q   <= 51'(t3_q) - 51'({ia_d[1], 16'd0});

      fx5_q   <= fx4_q;

      for (int k = 0; k < 4; k++)
        d6_q[k] <= 33'($signed(rd5_q[2*k+1])) - 33'($signed(rd5_q[2*k]));
      p2_6_q  <= rd5_q[2];
      fx6_q   <= fx5_q;

      d7_q    <= d6_q;
      m7_q    <= m7_d;
      p2_7_q  <= p2_6_q;
      fx7_q   <= fx6_q;

      d32_8_q <= d7_q[1];
      m2_8_q  <= m2_d;
      m3_8_q  <= m3_d;
      p2_8_q  <= p2_7_q;
      fx8_q   <= fx7_q;

      c3_9_q    <= 40'(m2_8_q) + 40'(m3_8_q) - 40'sd2 * 40'(d32_8_q);
      car9_q.c2 <= 40'sd3 * 40'(d32_8_q) - 40'sd2 * 40'(m2_8_q) - 40'(m3_8_q);
      car9_q.c1 <= m2_8_q;
      car9_q.p2 <= p2_8_q;
      car9_q.fx <= fx8_q;
    end
  end

  // knot store, eight copies, each read at one address per cycle while the pipeline advances
  logic wr_en;
  assign wr_en = en && v_q[4] && (kind4_q == KIND_WRITE) && (32'(idx4_q) < 32'(MAX_KNOTS));

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [31:0]   mem_q [MAX_KNOTS];
    logic [IW-1:0] raddr;
    assign raddr = (b % 2 == 1) ? ia4_q[b/2] + IW'(1) : ia4_q[b/2];
    always_ff @(posedge clk_i) begin
      if (wr_en) mem_q[IW'(idx4_q)] <= val4_q;
      if (en) rd5_q[b] <= mem_q[raddr];
    end
  end

  // horner steps: acc = sat(acc * fx + addend)
  logic signed [63:0] hs_acc [4];
  hcar_t              hs_car [4];
  logic               hs_v   [4];
  assign hs_acc[0] = 64'(c3_9_q);
  assign hs_car[0] = car9_q;
  assign hs_v[0]   = v_q[9];

  for (genvar g = 0; g < 3; g++) begin : g_horner
    logic        v1_q, v2_q, v3_q, v4_q;
    hcar_t       car1_q, car2_q, car3_q, car4_q;
    logic        neg1_q, neg2_q, neg3_q;
    logic [62:0] ua1_q;
    logic [50:0] ub1_q;
    logic [63:0] ll2_q;
    logic [50:0] lh2_q;
    logic [62:0] hl2_q;
    logic [49:0] hh2_q;
    logic [62:0] r3_q;
    logic signed [63:0] acc4_q;
    logic [113:0] full_w;
    logic [96:0]  rs_w;
    logic signed [64:0] add_w, sum_w;

    // sum of partial products, shifted and saturated
    always_comb begin
      full_w = 114'(ll2_q) + (114'(lh2_q) << 32) + (114'(hl2_q) << 32)
             + (114'(hh2_q) << 64);
      rs_w   = full_w[112:16];
    end

    // signed product plus addend, saturated
    always_comb begin
      case (g)
        0:       add_w = 65'(car3_q.c2);
        1:       add_w = 65'(car3_q.c1);
        default: add_w = 65'(car3_q.p2);
      endcase
      sum_w = (neg3_q ? -65'(r3_q) : 65'(r3_q)) + add_w;
      if (g == 2) begin
        if (sum_w < I32_NEG)      sum_w = I32_NEG;
        else if (sum_w > I32_POS) sum_w = I32_POS;
      end else begin
        if (sum_w < SAT_NEG)      sum_w = SAT_NEG;
        else if (sum_w > SAT_POS) sum_w = SAT_POS;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
        v3_q <= 1'b0;
        v4_q <= 1'b0;
      end else if (en) begin
        v1_q <= hs_v[g];
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ua1_q  <= hs_acc[g][63] ? 63'(-hs_acc[g]) : 63'(hs_acc[g]);
        ub1_q  <= hs_car[g].fx[50] ? 51'(-hs_car[g].fx) : 51'(hs_car[g].fx);
        neg1_q <= hs_acc[g][63] != hs_car[g].fx[50];
        car1_q <= hs_car[g];

        ll2_q  <= 64'(ua1_q[31:0]) * 64'(ub1_q[31:0]);
        lh2_q  <= 51'(ua1_q[31:0]) * 51'(ub1_q[50:32]);
        hl2_q  <= 63'(ua1_q[62:32]) * 63'(ub1_q[31:0]);
        hh2_q  <= 50'(ua1_q[62:32]) * 50'(ub1_q[50:32]);
        neg2_q <= neg1_q;
        car2_q <= car1_q;

        r3_q   <= (rs_w > SAT_MAG) ? 63'(SAT_MAG) : rs_w[62:0];
        neg3_q <= neg2_q;
        car3_q <= car2_q;

        acc4_q <= 64'(sum_w);
        car4_q <= car3_q;
      end
    end

    assign hs_acc[g+1] = acc4_q;
    assign hs_car[g+1] = car4_q;
    assign hs_v[g+1]   = v4_q;
  end

  // output register with final clamps, upper clamp applied last
  logic signed [31:0] h_w;
  always_comb begin
    h_w = hs_acc[3][31:0];
    if (h_w < lower_clamp_q) h_w = lower_clamp_q;
    if (h_w > upper_clamp_q) h_w = upper_clamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hs_v[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_value_q <= h_w;
  end

  // checks
  `MSWE_ASSERT_NOW(a_clamped, out_valid_o && lower_clamp_q <= upper_clamp_q, spline_value_o >= lower_clamp_q && spline_value_o <= upper_clamp_q)
  `MSWE_ASSERT_NEXT(a_write_drops, en && v_q[4] && kind4_q == KIND_WRITE, !v_q[5])
  `MSWE_ASSERT_NEXT(a_stall_holds, !en, $stable(v_q) && out_valid_q)

endmodule
